### hw/rtl/tds_pkg.sv
// ----------------------------------------------------------------------------
// tds_pkg
// Shared constants and a saturation function for the tridiagonal solver.
// ----------------------------------------------------------------------------
package tds_pkg;

  localparam int MaxRowsDef  = 64;
  localparam int FracBitsDef = 16;
  localparam int DataW       = 32;
  localparam int RowW        = 6;

  localparam logic signed [DataW-1:0] SatMax = {1'b0, {(DataW-1){1'b1}}};
  localparam logic signed [DataW-1:0] SatMin = {1'b1, {(DataW-1){1'b0}}};

  // saturate a 66-bit signed value to 32 bits
  function automatic logic [DataW:0] sat66(input logic signed [65:0] v);
    logic [DataW:0] res;
    begin
      if (v > 66'(signed'(SatMax))) res = {1'b1, SatMax};
      else if (v < 66'(signed'(SatMin))) res = {1'b1, SatMin};
      else res = {1'b0, v[DataW-1:0]};
      return res;
    end
  endfunction

endpackage

### hw/rtl/tds_div.sv
// ----------------------------------------------------------------------------
// tds_div
// Iterative signed fixed-point divider: (num << FRAC_BITS) / den, truncated
// toward zero, saturated to 32 bits. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module tds_div #(
  parameter int FRAC_BITS = tds_pkg::FracBitsDef
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            go,
  input  logic signed [tds_pkg::DataW-1:0] num,
  input  logic signed [tds_pkg::DataW-1:0] den,
  output logic                            done,
  output logic signed [tds_pkg::DataW-1:0] quot,
  output logic                            zero_den,
  output logic                            sat
);
  localparam int NW = tds_pkg::DataW + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0]   q_r, q_nxt;
  logic [tds_pkg::DataW:0] rem_r, rem_nxt;
  logic [tds_pkg::DataW-1:0] d_r;
  logic            neg_r, busy_r, zd_r, done_r;
  logic [CW-1:0]   cnt_r;
  logic [tds_pkg::DataW:0] sh;
  logic [tds_pkg::DataW-1:0] an, ad;
  logic signed [65:0] sq;
  logic [tds_pkg::DataW:0] sr;

  assign an = num[tds_pkg::DataW-1] ? tds_pkg::DataW'(-num) : num;
  assign ad = den[tds_pkg::DataW-1] ? tds_pkg::DataW'(-den) : den;

  always_comb begin
    sh = {rem_r[tds_pkg::DataW-1:0], q_r[NW-1]};
    q_nxt = {q_r[NW-2:0], 1'b0};
    rem_nxt = sh;
    if (sh >= {1'b0, d_r}) begin
      rem_nxt = sh - {1'b0, d_r};
      q_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        q_r    <= {an, FRAC_BITS'(0)};
        rem_r  <= '0;
        d_r    <= ad;
        neg_r  <= num[tds_pkg::DataW-1] ^ den[tds_pkg::DataW-1];
        zd_r   <= (den == '0);
        cnt_r  <= CW'(NW);
        busy_r <= (den != '0);
        done_r <= (den == '0);
      end else if (busy_r) begin
        q_r   <= q_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    sq = neg_r ? -66'(q_r) : 66'(q_r);
    sr = tds_pkg::sat66(sq);
    if (zd_r) begin
      quot = '0;
      sat  = 1'b0;
    end else begin
      quot = sr[tds_pkg::DataW-1:0];
      sat  = sr[tds_pkg::DataW];
    end
  end
  assign done = done_r;
  assign zero_den = zd_r;
endmodule

### hw/rtl/tridiagonal_system_solver_top.sv
// ----------------------------------------------------------------------------
// tridiagonal_system_solver_top
// Thomas-algorithm tridiagonal solver in signed fixed point.
// ----------------------------------------------------------------------------
// Usage: drive one row with start while busy is low; the transaction is taken
// at that edge. Forward elimination divides by the previous pivot in a shared
// bit-serial divider, then takes one multiply step and writes the row to
// memory; row zero skips the divide and the multiply. The block takes no new
// row until the current one is written.
// On last_row, or when MAX_ROWS rows are held, back substitution runs per row
// through a memory read, one multiply and the same divider; each solution is
// written back over its rhs entry. Once all rows are solved, the solutions
// leave on out_valid for one cycle each, highest row first, all carrying the
// flags of the whole solve; last_result marks row zero. busy stays high until
// the run ends, then the block is back at its reset state.
// Reset clears the sequencer, row count, previous-row registers and flags.
// The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module tridiagonal_system_solver_top #(
  parameter int MAX_ROWS  = tds_pkg::MaxRowsDef,
  parameter int FRAC_BITS = tds_pkg::FracBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic signed [31:0] in_sub_diag,
  input  logic signed [31:0] in_main_diag,
  input  logic signed [31:0] in_super_diag,
  input  logic signed [31:0] in_rhs_value,
  input  logic        in_last_row,
  output logic        out_valid,
  output logic signed [31:0] out_solution,
  output logic [5:0]  out_row_index,
  output logic        out_last_result,
  output logic        out_pivot_zero,
  output logic        out_saturated
);
  localparam int AW = $clog2(MAX_ROWS);
  localparam int CW = AW + 1;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001, S_FDIV = 10'b0000000010, S_FMUL = 10'b0000000100,
    S_FWR  = 10'b0000001000, S_BRD  = 10'b0000010000, S_BMUL = 10'b0000100000,
    S_BDIV = 10'b0001000000, S_BOUT = 10'b0010000000, S_ORD  = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } state_t;

  state_t state_r;
  logic [CW-1:0] cnt_r;
  logic [AW-1:0] idx_r;
  logic first_r;
  logic signed [31:0] pp_r, pr_r, pu_r, b_r, d_r, c_r, m_r, piv_r, r_r;
  logic signed [31:0] t_r, x_r;
  logic pz_r, sat_r, end_r;
  logic signed [31:0] piv_mem [MAX_ROWS];
  logic signed [31:0] rhs_mem [MAX_ROWS];
  logic signed [31:0] up_mem  [MAX_ROWS];
  logic signed [31:0] mp_r, mr_r, mu_r;

  logic dgo, ddone, dzero, dsat;
  logic signed [31:0] dnum, dden, dq;

  tds_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk, .rst_n, .go(dgo), .num(dnum), .den(dden),
    .done(ddone), .quot(dq), .zero_den(dzero), .sat(dsat)
  );

  // shared multiplier: floor(ma*mb / 2^F), operands muxed by state
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;
  logic signed [65:0] s1, s2;
  logic [32:0] s1s, s2s;
  always_comb begin
    ma = (state_r == S_FMUL) ? m_r : mu_r;
    mb = (state_r == S_FMUL) ? pu_r : x_r;
    prod = ma * mb;
    s1 = 66'(signed'(b_r)) - 66'(prod >>> FRAC_BITS);
    s2 = 66'(signed'(d_r)) - 66'(signed'(m_r) * signed'(pr_r) >>> FRAC_BITS);
    s1s = tds_pkg::sat66(s1);
    s2s = tds_pkg::sat66(s2);
  end
  // back-substitution residual
  logic signed [65:0] s3;
  logic [32:0] s3s;
  assign s3  = 66'(signed'(mr_r)) - 66'(prod >>> FRAC_BITS);
  assign s3s = tds_pkg::sat66(s3);

  // first_r marks the first cycle of either divide state
  assign dgo = first_r && (state_r == S_FDIV || state_r == S_BDIV);
  assign dnum = (state_r == S_FDIV) ? m_r : t_r;
  assign dden = (state_r == S_FDIV) ? pp_r : mp_r;

  always_ff @(posedge clk) begin
    if (state_r == S_FWR) begin
      piv_mem[idx_r] <= piv_r;
      rhs_mem[idx_r] <= r_r;
      up_mem[idx_r]  <= c_r;
    end else if (state_r == S_BDIV && ddone) begin
      rhs_mem[idx_r] <= dq;
    end
    mp_r <= piv_mem[idx_r];
    mr_r <= rhs_mem[idx_r];
    mu_r <= up_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      pp_r <= '0; pr_r <= '0; pu_r <= '0;
      pz_r <= 1'b0; sat_r <= 1'b0;
      out_valid <= 1'b0;
      first_r <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      first_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (start) begin
          b_r <= in_main_diag; d_r <= in_rhs_value; c_r <= in_super_diag;
          m_r <= in_sub_diag;
          end_r <= in_last_row || (cnt_r == CW'(MAX_ROWS - 1));
          idx_r <= cnt_r[AW-1:0];
          if (cnt_r == '0) begin
            piv_r <= in_main_diag; r_r <= in_rhs_value;
            state_r <= S_FWR;
          end else begin
            first_r <= 1'b1;
            state_r <= S_FDIV;
          end
        end
        S_FDIV: if (ddone) begin
          m_r <= dq;
          pz_r <= pz_r | dzero;
          sat_r <= sat_r | dsat;
          state_r <= S_FMUL;
        end
        S_FMUL: begin
          piv_r <= s1s[31:0]; r_r <= s2s[31:0];
          sat_r <= sat_r | s1s[32] | s2s[32];
          state_r <= S_FWR;
        end
        S_FWR: begin
          if (piv_r == '0) pz_r <= 1'b1;
          pp_r <= piv_r; pr_r <= r_r; pu_r <= c_r;
          if (end_r) begin
            first_r <= 1'b1;
            state_r <= S_BRD;
          end else begin
            cnt_r <= cnt_r + 1'b1;
            state_r <= S_IDLE;
          end
        end
        S_BRD: begin  // memory read latency
          first_r <= first_r;
          state_r <= S_BMUL;
        end
        S_BMUL: begin
          // first_r marks the top row, which has no upper term
          t_r <= first_r ? mr_r : s3s[31:0];
          if (!first_r) sat_r <= sat_r | s3s[32];
          first_r <= 1'b1;
          state_r <= S_BDIV;
        end
        S_BDIV: if (ddone) begin
          x_r <= dq;
          pz_r <= pz_r | dzero;
          sat_r <= sat_r | dsat;
          state_r <= S_BOUT;
        end
        S_BOUT: begin
          if (idx_r == '0) begin
            idx_r <= cnt_r[AW-1:0];
            state_r <= S_ORD;
          end else begin
            idx_r <= idx_r - 1'b1;
            state_r <= S_BRD;
          end
        end
        S_ORD: state_r <= S_OUT;  // solution read latency
        S_OUT: begin
          out_solution <= mr_r;
          out_row_index <= 6'(idx_r);
          out_last_result <= (idx_r == '0);
          out_pivot_zero <= pz_r;
          out_saturated <= sat_r;
          out_valid <= 1'b1;
          if (idx_r == '0) begin
            state_r <= S_IDLE;
            cnt_r <= '0;
            pp_r <= '0; pr_r <= '0; pu_r <= '0;
            pz_r <= 1'b0; sat_r <= 1'b0;
          end else begin
            idx_r <= idx_r - 1'b1;
            state_r <= S_ORD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_r != S_IDLE);
endmodule

### tb/tb_tridiagonal_system_solver_top.sv
// ----------------------------------------------------------------------------
// tb_tridiagonal_system_solver_top
// Self-checking bench for the Thomas-algorithm tridiagonal solver.
// Rows go in one at a time, and a fixed-point model works out each solve.
// Every solution strobe is checked against the queued prediction. The
// stimulus covers directed corner cases, a full store, and random systems.
// ----------------------------------------------------------------------------
module tb_tridiagonal_system_solver_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  MaxRows   = tds_pkg::MaxRowsDef;
  localparam int  FracBits  = tds_pkg::FracBitsDef;
  localparam longint CycleLimit = 2000000;
  localparam int  DrainCycles = 4 * (FracBits + 40);

  typedef struct {
    logic signed [31:0] solution;
    logic [5:0]         row_index;
    logic               last_result;
    logic               pivot_zero;
    logic               saturated;
  } solution_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] in_sub_diag = '0;
  logic signed [31:0] in_main_diag = '0;
  logic signed [31:0] in_super_diag = '0;
  logic signed [31:0] in_rhs_value = '0;
  logic in_last_row = 1'b0;
  logic out_valid;
  logic signed [31:0] out_solution;
  logic [5:0] out_row_index;
  logic out_last_result, out_pivot_zero, out_saturated;

  tridiagonal_system_solver_top i_dut (
    .clk, .rst_n, .start, .busy,
    .in_sub_diag, .in_main_diag, .in_super_diag, .in_rhs_value, .in_last_row,
    .out_valid, .out_solution, .out_row_index, .out_last_result,
    .out_pivot_zero, .out_saturated
  );

  always #5 clk = ~clk;

  // solver state mirror
  int unsigned rows_held;
  longint piv_mem [MaxRows];
  longint rhs_mem [MaxRows];
  longint upr_mem [MaxRows];
  longint last_piv, last_rhs, last_upr;
  bit pz_flag, sat_flag;
  solution_t solution_q[$];

  int errors = 0;
  int rows_sent = 0;
  int solutions_seen = 0;
  int systems_solved = 0;
  longint cycles = 0;

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) begin
      sat_flag = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat_flag = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return (a * b) >>> FracBits;  // arithmetic shift floors
  endfunction

  function automatic longint fx_div(longint num, longint den);
    if (den == 0) begin
      pz_flag = 1'b1;
      return 0;
    end
    return (num <<< FracBits) / den;
  endfunction

  function automatic void clear_solver();
    rows_held = 0;
    last_piv = 0;
    last_rhs = 0;
    last_upr = 0;
    pz_flag = 1'b0;
    sat_flag = 1'b0;
  endfunction

  // forward elimination for one row; back substitution when the system closes
  function automatic void eliminate_row(logic signed [31:0] a, logic signed [31:0] b,
                                        logic signed [31:0] c, logic signed [31:0] d,
                                        logic lst);
    longint m, piv, r, t, xn;
    longint xs [MaxRows];
    int unsigned idx, n;
    solution_t s;
    idx = rows_held % MaxRows;
    if (idx == 0) begin
      piv = b;
      r = d;
    end else begin
      m = clip32(fx_div(a, last_piv));
      piv = clip32(b - fx_mul(m, last_upr));
      r = clip32(d - fx_mul(m, last_rhs));
    end
    if (piv == 0) pz_flag = 1'b1;
    piv_mem[idx] = piv;
    rhs_mem[idx] = r;
    upr_mem[idx] = c;
    last_piv = piv;
    last_rhs = r;
    last_upr = c;
    rows_held = idx + 1;
    if (!lst && rows_held < MaxRows) return;
    n = rows_held;
    xn = 0;
    for (int i = n - 1; i >= 0; i--) begin
      if (i == n - 1) t = rhs_mem[i];
      else t = clip32(rhs_mem[i] - fx_mul(upr_mem[i], xn));
      xn = clip32(fx_div(t, piv_mem[i]));
      xs[i] = xn;
    end
    for (int i = n - 1; i >= 0; i--) begin
      s.solution = xs[i][31:0];
      s.row_index = 6'(i);
      s.last_result = (i == 0);
      s.pivot_zero = pz_flag;
      s.saturated = sat_flag;
      solution_q.push_back(s);
    end
    systems_solved++;
    clear_solver();
  endfunction

  // start stays high after acceptance; the caller lowers it with idle_cycles
  task automatic send_row(logic signed [31:0] a, logic signed [31:0] b,
                          logic signed [31:0] c, logic signed [31:0] d, logic lst);
    start <= 1'b1;
    in_sub_diag <= a;
    in_main_diag <= b;
    in_super_diag <= c;
    in_rhs_value <= d;
    in_last_row <= lst;
    do @(posedge clk); while (busy);
    eliminate_row(a, b, c, d, lst);
    rows_sent++;
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    idle_cycles(1);
    while (solution_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [31:0] q16(int v);
    return 32'(v) <<< FracBits;
  endfunction

  task automatic test_single_row();
    send_row(32'sh7fffffff, q16(2), 32'sh7fffffff, q16(6), 1'b1);
    send_row('0, q16(1), '0, 32'sh80000000, 1'b1);
    send_row('0, 32'sh0000_0100, '0, 32'sh7fffffff, 1'b1);  // saturates
    send_row('0, '0, '0, q16(3), 1'b1);                     // zero pivot, zero divisor
    wait_drained();
  endtask

  task automatic test_corner_rows();
    // two-row well-posed system
    send_row(q16(9), q16(4), q16(1), q16(5), 1'b0);
    send_row(q16(1), q16(4), q16(7), q16(6), 1'b1);
    // eliminated pivot comes out zero
    send_row('0, q16(1), q16(1), q16(1), 1'b0);
    send_row(q16(1), q16(1), '0, q16(2), 1'b1);
    // extremes of every field
    send_row(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 1'b0);
    send_row(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 1'b0);
    send_row(32'sh7fffffff, 32'sh00000001, 32'shffffffff, 32'shffffffff, 1'b1);
    // negative pivots and rhs
    send_row(q16(3), -q16(2), q16(-1), -q16(8), 1'b0);
    send_row(-q16(1), -q16(5), q16(2), q16(4), 1'b0);
    send_row(q16(2), q16(3), q16(9), -q16(1), 1'b1);
    wait_drained();
  endtask

  task automatic test_full_store();
    // the 64th row closes the system without last_row
    for (int i = 0; i < MaxRows; i++)
      send_row(-q16(1), q16(4), -q16(1), q16(i - 30), 1'b0);
    wait_drained();
    // store filled exactly when last_row is also set
    for (int i = 0; i < MaxRows; i++)
      send_row(q16(1), q16(3), q16(1), q16(i), i == MaxRows - 1);
    wait_drained();
  endtask

  function automatic logic signed [31:0] rand_coef(int span);
    return 32'($signed($urandom_range(2 * span, 0)) - span) <<< (FracBits - 4);
  endfunction

  task automatic test_random_systems(int target);
    int burst, len, kind;
    logic signed [31:0] a, b, c, d;
    burst = $urandom_range(12, 1);
    while (rows_sent < target) begin
      kind = $urandom_range(99, 0);
      len = (kind < 5) ? $urandom_range(MaxRows, 20) : $urandom_range(8, 1);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(9, 0) == 0) begin
          // noise row: raw 32-bit fields
          a = $urandom; b = $urandom; c = $urandom; d = $urandom;
        end else begin
          a = rand_coef(16);
          c = rand_coef(16);
          b = rand_coef(64);
          b = b + (b[31] ? -q16(3) : q16(3));  // keep pivots away from zero
          d = rand_coef(1600);
        end
        send_row(a, b, c, d, i == len - 1);
        burst = burst - 1;
        if (burst == 0) begin
          idle_cycles($urandom_range(8, 1));
          burst = $urandom_range(12, 1);
        end
      end
      // sometimes hold off until the whole solve has come out
      if ($urandom_range(7, 0) == 0) wait_drained();
    end
    wait_drained();
  endtask

  always @(posedge clk) begin
    solution_t exp_s;
    if (rst_n && out_valid) begin
      solutions_seen++;
      if (solution_q.size() == 0) begin
        $display("%0t: unexpected solution row %0d value %0d", $time, out_row_index,
                 out_solution);
        errors++;
      end else begin
        exp_s = solution_q.pop_front();
        if (out_solution !== exp_s.solution) begin
          $display("%0t: solution row %0d expected %0d actual %0d", $time,
                   exp_s.row_index, exp_s.solution, out_solution);
          errors++;
        end
        if (out_row_index !== exp_s.row_index) begin
          $display("%0t: row_index expected %0d actual %0d", $time, exp_s.row_index,
                   out_row_index);
          errors++;
        end
        if (out_last_result !== exp_s.last_result) begin
          $display("%0t: last_result expected %0b actual %0b", $time,
                   exp_s.last_result, out_last_result);
          errors++;
        end
        if (out_pivot_zero !== exp_s.pivot_zero) begin
          $display("%0t: pivot_zero expected %0b actual %0b", $time, exp_s.pivot_zero,
                   out_pivot_zero);
          errors++;
        end
        if (out_saturated !== exp_s.saturated) begin
          $display("%0t: saturated expected %0b actual %0b", $time, exp_s.saturated,
                   out_saturated);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("%0t: timeout with %0d solutions outstanding", $time, solution_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    clear_solver();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_single_row();
    test_corner_rows();
    test_full_store();
    test_random_systems(470);
    repeat (DrainCycles) @(posedge clk);
    if (solution_q.size() != 0) begin
      $display("%0t: %0d solutions never arrived", $time, solution_q.size());
      errors++;
    end
    $display("Sent %0d rows in %0d systems, checked %0d solutions.", rows_sent,
             systems_solved, solutions_seen);
    $display("Covered single rows, zero pivots, saturation, full stores, random systems.");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
